@@ rtl/sensor_frame_calibration_matrix_core_macros.svh @@
// Assertion macros used by the calibration matrix top level.
`ifndef SENSOR_FRAME_CALIBRATION_MATRIX_CORE_MACROS_SVH
`define SENSOR_FRAME_CALIBRATION_MATRIX_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFCM_ASSERT_NOW(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SFCM_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/sfcm_pkg.sv @@
// Types, constants and the arctangent table of the calibration matrix block.
package sfcm_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;

    localparam int OUT_BITS  = 16;
    localparam int QFRAC     = 30;
    localparam int QW        = 36;
    localparam int CW        = QW + 4;
    localparam int RW        = 34;
    localparam int ANG_BITS  = 32;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [OUT_BITS-1:0]    entry_t;
    typedef logic signed [QW-1:0]          vec_t;
    typedef logic signed [CW-1:0]          cw_t;
    typedef logic signed [RW-1:0]          rw_t;
    typedef logic [ANG_BITS-1:0]           angle_t;

    typedef struct packed {
        sample_t gravity_x;
        sample_t gravity_y;
        sample_t gravity_z;
        sample_t second_x;
        sample_t second_y;
        sample_t second_z;
    } in_item_t;

    typedef struct packed {
        entry_t r0c0;
        entry_t r0c1;
        entry_t r0c2;
        entry_t r1c0;
        entry_t r1c1;
        entry_t r1c2;
        entry_t r2c0;
        entry_t r2c1;
        entry_t r2c2;
    } out_item_t;

    typedef struct packed {
        vec_t v0;
        vec_t v1;
        vec_t v2;
    } vec3_t;

    typedef struct packed {
        vec_t c;
        vec_t s;
    } cs_pair_t;

    typedef vec_t [2:0][2:0] mat_t;

    localparam angle_t HALF_TURN = 32'h8000_0000;
    localparam rw_t    GAIN_Q30  = RW'(64'sd652032874);

    localparam angle_t ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Arctangent of 2^-i as a binary angle.
    function automatic angle_t atan_step(logic [4:0] idx);
        return ATAN_TAB[idx];
    endfunction

endpackage

@@ rtl/sfcm_vec_cordic.sv @@
// Pipelined vectoring CORDIC: binary angle of a vector (x, y).
module sfcm_vec_cordic import sfcm_pkg::*; (
    input  logic   aclk,
    input  logic   en,
    input  vec_t   x_in,
    input  vec_t   y_in,
    output angle_t ang_out
);

    cw_t    x_reg [CORDIC_STEPS+1];
    cw_t    y_reg [CORDIC_STEPS+1];
    angle_t z_reg [CORDIC_STEPS+1];

    // Move a vector in the left half-plane over by half a turn.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (x_in < 0) begin
                x_reg[0] <= -cw_t'(x_in);
                y_reg[0] <= -cw_t'(y_in);
                z_reg[0] <= HALF_TURN;
            end else begin
                x_reg[0] <= cw_t'(x_in);
                y_reg[0] <= cw_t'(y_in);
                z_reg[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage, driving y towards zero.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        cw_t dx;
        cw_t dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_step(5'(i));
                end else if (y_reg[i] < 0) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_step(5'(i));
                end else begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end
            end
        end
    end

    assign ang_out = z_reg[CORDIC_STEPS];

endmodule

@@ rtl/sfcm_rot_cordic.sv @@
// Pipelined rotation CORDIC: cosine and sine of a binary angle in Q30.
module sfcm_rot_cordic import sfcm_pkg::*; (
    input  logic   aclk,
    input  logic   en,
    input  angle_t ang_in,
    output vec_t   cos_out,
    output vec_t   sin_out
);

    rw_t    x_reg [CORDIC_STEPS+1];
    rw_t    y_reg [CORDIC_STEPS+1];
    rw_t    z_reg [CORDIC_STEPS+1];
    logic   [CORDIC_STEPS:0] neg_reg;
    vec_t   cos_reg;
    vec_t   sin_reg;
    logic   flip;
    angle_t ang_adj;

    // Angles in the left half are folded by half a turn and negated at the end.
    assign flip    = ang_in[ANG_BITS-1:ANG_BITS-2] inside {2'b01, 2'b10};
    assign ang_adj = flip ? (ang_in + HALF_TURN) : ang_in;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= rw_t'($signed(ang_adj));
            neg_reg[0] <= flip;
        end
    end

    // One micro-rotation per stage, driving the residual angle towards zero.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        rw_t dx;
        rw_t dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - rw_t'(atan_step(5'(i)));
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + rw_t'(atan_step(5'(i)));
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // Undo the fold on the way out.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (neg_reg[CORDIC_STEPS]) begin
                cos_reg <= -vec_t'(x_reg[CORDIC_STEPS]);
                sin_reg <= -vec_t'(y_reg[CORDIC_STEPS]);
            end else begin
                cos_reg <= vec_t'(x_reg[CORDIC_STEPS]);
                sin_reg <= vec_t'(y_reg[CORDIC_STEPS]);
            end
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

@@ rtl/sfcm_qmul.sv @@
// Two-stage Q30 multiplier, product floored by 2^30, split into two partial products.
module sfcm_qmul import sfcm_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  vec_t a,
    input  vec_t b,
    output vec_t p
);

    localparam int LO_W = QW / 2;
    localparam int HI_W = QW - LO_W;

    logic signed [HI_W-1:0]      a_hi;
    logic signed [LO_W:0]        a_lo;
    logic signed [HI_W+QW-1:0]   hi_reg;
    logic signed [LO_W+QW:0]     lo_reg;
    logic signed [2*QW-1:0]      sum;
    vec_t                        p_reg;

    // Upper half signed, lower half unsigned.
    assign a_hi = a[QW-1:LO_W];
    assign a_lo = {1'b0, a[LO_W-1:0]};

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_reg <= (HI_W+QW)'(a_hi) * (HI_W+QW)'(b);
            lo_reg <= (LO_W+QW+1)'(a_lo) * (LO_W+QW+1)'(b);
        end
    end

    // Recombine and drop the fraction bits, which rounds towards minus infinity.
    assign sum = ((2*QW)'(hi_reg) <<< LO_W) + (2*QW)'(lo_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= sum[QFRAC+QW-1:QFRAC];
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/sensor_frame_calibration_matrix_core.sv @@
// Top level of the sensor frame calibration matrix pipeline.
//
// Usage: a request on the s_ channel carries a gravity vector and a second
// vector; the block answers each with one 3x3 rotation on the m_ channel,
// nine Q1.14 entries in row-major order, saturated to plus or minus one.
// Both channels use valid and ready; a request moves when both are high.
// The path is three rounds of a vectoring CORDIC, a rotation CORDIC and
// two-stage multipliers, all fully pipelined.
// Throughput: one request per cycle while the receiver does not stall; the
// pipeline holds up to 119 requests.
// The whole pipeline advances under one enable that is high while the output
// register is empty or being read, so a stalled receiver freezes every stage
// and s_ready falls; bubbles in flight are preserved and nothing is lost.
// Reset clears every valid bit; the data registers are not reset.
`include "sensor_frame_calibration_matrix_core_macros.svh"

module sensor_frame_calibration_matrix_core import sfcm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int LV  = CORDIC_STEPS + 1;
    localparam int LR  = CORDIC_STEPS + 2;
    localparam int LM  = 2;
    localparam int T1  = LV + LR;
    localparam int T2  = T1 + LM + 1;
    localparam int T3  = T2 + LV + LR;
    localparam int T4  = T3 + LM;
    localparam int T5  = T4 + 1;
    localparam int T6  = T5 + LM + 1;
    localparam int T7  = T6 + LV + LR;
    localparam int LAT = T7 + LM + 2;

    localparam int CS1_D = T4 - T1;
    localparam int A_D   = T7 - T5 + LM;
    localparam int SH    = QFRAC - FRAC_BITS;
    localparam int SCALE = 32 - SAMPLE_BITS;

    localparam logic signed [QW:0] RND = (QW+1)'((64'(1) << SH) >> 1);
    localparam logic signed [QW:0] LIM = (QW+1)'(64'(1) << FRAC_BITS);
    localparam logic signed [OUT_BITS:0] OUT_LIM = (OUT_BITS+1)'(64'(1) << FRAC_BITS);

    logic             adv;
    logic [LAT:0]     vld_reg;
    logic [LAT:0]     vld_next;

    vec3_t            g_reg;
    vec3_t            h_reg;
    vec3_t            g_dly_reg [T2];
    vec3_t            h_dly_reg [T5];
    cs_pair_t         cs1_dly_reg [CS1_D];
    cs_pair_t         cs2_dly_reg [LM];
    mat_t             a_dly_reg [A_D];

    angle_t           a1;
    angle_t           a2;
    angle_t           a3;
    vec_t             c1;
    vec_t             s1;
    vec_t             c2;
    vec_t             s2;
    vec_t             c3;
    vec_t             s3;

    vec_t             mw0;
    vec_t             mw1;
    vec_t             w0_reg;
    vec_t             ma [4];
    mat_t             a_reg;
    mat_t             a_next;
    vec_t             mu [5];
    vec_t             u0_reg;
    vec_t             u1_reg;
    vec_t             rp [3][4];
    mat_t             res_reg;
    out_item_t        out_reg;

    vec3_t            g_t1;
    vec3_t            g_t2;
    cs_pair_t         cs1_t3;
    cs_pair_t         cs1_t4;
    cs_pair_t         cs2_t4;
    mat_t             a_t7;
    mat_t             a_t10;
    vec3_t            h_t5;

    // Round half up to the output fraction, then saturate to plus or minus one.
    function automatic entry_t to_out(vec_t v);
        logic signed [QW:0] t;
        t = (QW+1)'(v) + RND;
        t = t >>> SH;
        if (t > LIM) begin
            t = LIM;
        end else if (t < -LIM) begin
            t = -LIM;
        end
        return t[OUT_BITS-1:0];
    endfunction

    // One enable for the whole pipeline; it only stops for a waiting result.
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Valid bits travel alongside the data.
    assign vld_next = {vld_reg[LAT-1:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // Input stage: samples scaled to 32-bit full scale.
    always_ff @(posedge aclk) begin
        if (adv) begin
            g_reg.v0 <= vec_t'(s_data.gravity_x) <<< SCALE;
            g_reg.v1 <= vec_t'(s_data.gravity_y) <<< SCALE;
            g_reg.v2 <= vec_t'(s_data.gravity_z) <<< SCALE;
            h_reg.v0 <= vec_t'(s_data.second_x) <<< SCALE;
            h_reg.v1 <= vec_t'(s_data.second_y) <<< SCALE;
            h_reg.v2 <= vec_t'(s_data.second_z) <<< SCALE;
        end
    end

    // Delay lines that keep operands aligned with the CORDIC results.
    always_ff @(posedge aclk) begin
        if (adv) begin
            g_dly_reg[0]   <= g_reg;
            h_dly_reg[0]   <= h_reg;
            cs1_dly_reg[0] <= '{c: c1, s: s1};
            cs2_dly_reg[0] <= '{c: c2, s: s2};
            a_dly_reg[0]   <= a_reg;
            for (int k = 1; k < T2; k++) begin
                g_dly_reg[k] <= g_dly_reg[k-1];
            end
            for (int k = 1; k < T5; k++) begin
                h_dly_reg[k] <= h_dly_reg[k-1];
            end
            for (int k = 1; k < CS1_D; k++) begin
                cs1_dly_reg[k] <= cs1_dly_reg[k-1];
            end
            for (int k = 1; k < LM; k++) begin
                cs2_dly_reg[k] <= cs2_dly_reg[k-1];
            end
            for (int k = 1; k < A_D; k++) begin
                a_dly_reg[k] <= a_dly_reg[k-1];
            end
        end
    end

    assign g_t1   = g_dly_reg[T1-1];
    assign g_t2   = g_dly_reg[T2-1];
    assign h_t5   = h_dly_reg[T5-1];
    assign cs1_t3 = cs1_dly_reg[T3-T1-1];
    assign cs1_t4 = cs1_dly_reg[CS1_D-1];
    assign cs2_t4 = cs2_dly_reg[LM-1];
    assign a_t7   = a_dly_reg[T7-T5-1];
    assign a_t10  = a_dly_reg[A_D-1];

    // First round: heading of gravity in the XY plane, rotation about Z.
    sfcm_vec_cordic u_vec1 (
        .aclk    (aclk),
        .en      (adv),
        .x_in    (g_reg.v0),
        .y_in    (g_reg.v1),
        .ang_out (a1)
    );

    sfcm_rot_cordic u_rot1 (
        .aclk    (aclk),
        .en      (adv),
        .ang_in  (-a1),
        .cos_out (c1),
        .sin_out (s1)
    );

    // x component of gravity after the first rotation.
    sfcm_qmul u_mw0 (.aclk(aclk), .en(adv), .a(g_t1.v0), .b(c1), .p(mw0));
    sfcm_qmul u_mw1 (.aclk(aclk), .en(adv), .a(g_t1.v1), .b(-s1), .p(mw1));

    always_ff @(posedge aclk) begin
        if (adv) begin
            w0_reg <= mw0 + mw1;
        end
    end

    // Second round: tilt of gravity against Z, rotation about Y.
    sfcm_vec_cordic u_vec2 (
        .aclk    (aclk),
        .en      (adv),
        .x_in    (g_t2.v2),
        .y_in    (w0_reg),
        .ang_out (a2)
    );

    sfcm_rot_cordic u_rot2 (
        .aclk    (aclk),
        .en      (adv),
        .ang_in  (a2),
        .cos_out (c2),
        .sin_out (s2)
    );

    // Combined rotation; entries against zero or one need no multiplier.
    sfcm_qmul u_ma0 (.aclk(aclk), .en(adv), .a(cs1_t3.c), .b(c2), .p(ma[0]));
    sfcm_qmul u_ma1 (.aclk(aclk), .en(adv), .a(cs1_t3.c), .b(s2), .p(ma[1]));
    sfcm_qmul u_ma2 (.aclk(aclk), .en(adv), .a(-cs1_t3.s), .b(c2), .p(ma[2]));
    sfcm_qmul u_ma3 (.aclk(aclk), .en(adv), .a(-cs1_t3.s), .b(s2), .p(ma[3]));

    always_comb begin
        a_next[0][0] = ma[0];
        a_next[0][1] = cs1_t4.s;
        a_next[0][2] = ma[1];
        a_next[1][0] = ma[2];
        a_next[1][1] = cs1_t4.c;
        a_next[1][2] = ma[3];
        a_next[2][0] = -cs2_t4.s;
        a_next[2][1] = '0;
        a_next[2][2] = cs2_t4.c;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg <= a_next;
        end
    end

    // Second vector taken into the levelled frame.
    sfcm_qmul u_mu0 (.aclk(aclk), .en(adv), .a(h_t5.v0), .b(a_reg[0][0]), .p(mu[0]));
    sfcm_qmul u_mu1 (.aclk(aclk), .en(adv), .a(h_t5.v1), .b(a_reg[1][0]), .p(mu[1]));
    sfcm_qmul u_mu2 (.aclk(aclk), .en(adv), .a(h_t5.v2), .b(a_reg[2][0]), .p(mu[2]));
    sfcm_qmul u_mu3 (.aclk(aclk), .en(adv), .a(h_t5.v0), .b(a_reg[0][1]), .p(mu[3]));
    sfcm_qmul u_mu4 (.aclk(aclk), .en(adv), .a(h_t5.v1), .b(a_reg[1][1]), .p(mu[4]));

    always_ff @(posedge aclk) begin
        if (adv) begin
            u0_reg <= mu[0] + mu[1] + mu[2];
            u1_reg <= mu[3] + mu[4];
        end
    end

    // Third round: heading of the second vector, rotation about Z.
    sfcm_vec_cordic u_vec3 (
        .aclk    (aclk),
        .en      (adv),
        .x_in    (u0_reg),
        .y_in    (u1_reg),
        .ang_out (a3)
    );

    sfcm_rot_cordic u_rot3 (
        .aclk    (aclk),
        .en      (adv),
        .ang_in  (-a3),
        .cos_out (c3),
        .sin_out (s3)
    );

    // Final product, one row of multipliers per matrix row.
    for (genvar r = 0; r < 3; r++) begin : g_row
        sfcm_qmul u_p0 (.aclk(aclk), .en(adv), .a(a_t7[r][0]), .b(c3), .p(rp[r][0]));
        sfcm_qmul u_p1 (.aclk(aclk), .en(adv), .a(a_t7[r][1]), .b(-s3), .p(rp[r][1]));
        sfcm_qmul u_p2 (.aclk(aclk), .en(adv), .a(a_t7[r][0]), .b(s3), .p(rp[r][2]));
        sfcm_qmul u_p3 (.aclk(aclk), .en(adv), .a(a_t7[r][1]), .b(c3), .p(rp[r][3]));

        always_ff @(posedge aclk) begin
            if (adv) begin
                res_reg[r][0] <= rp[r][0] + rp[r][1];
                res_reg[r][1] <= rp[r][2] + rp[r][3];
                res_reg[r][2] <= a_t10[r][2];
            end
        end
    end

    // Output register: rounding and saturation to Q1.14.
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.r0c0 <= to_out(res_reg[0][0]);
            out_reg.r0c1 <= to_out(res_reg[0][1]);
            out_reg.r0c2 <= to_out(res_reg[0][2]);
            out_reg.r1c0 <= to_out(res_reg[1][0]);
            out_reg.r1c1 <= to_out(res_reg[1][1]);
            out_reg.r1c2 <= to_out(res_reg[1][2]);
            out_reg.r2c0 <= to_out(res_reg[2][0]);
            out_reg.r2c1 <= to_out(res_reg[2][1]);
            out_reg.r2c2 <= to_out(res_reg[2][2]);
        end
    end

    assign m_valid = vld_reg[LAT];
    assign m_data  = out_reg;

    // An accepted request occupies the first stage on the next cycle.
    `SFCM_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, vld_reg[0], "accepted request missing from first stage")
    // A stall freezes every valid bit in the pipeline.
    `SFCM_ASSERT_NEXT(a_stall_freezes, aclk, aresetn, !adv, $stable(vld_reg), "pipeline moved during a stall")
    // Saturation keeps delivered entries within plus or minus one.
    `SFCM_ASSERT_NOW(a_out_range, aclk, aresetn, m_valid && (FRAC_BITS <= 14), (m_data.r0c0 <= OUT_LIM) && (m_data.r0c0 >= -OUT_LIM) && (m_data.r1c1 <= OUT_LIM) && (m_data.r1c1 >= -OUT_LIM) && (m_data.r2c2 <= OUT_LIM) && (m_data.r2c2 >= -OUT_LIM), "output entry outside saturation range")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the sensor frame calibration matrix core.
module testbench;
    import sfcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RESET_CYCLES = 12;
    localparam int  DRAIN_CYCLES = 200;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  HOLD_CYCLES  = 400;
    localparam longint GAIN      = 64'sd652032874;
    localparam longint Q_ONE     = 64'sd1073741824;

    typedef longint mat3_t [3][3];

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    in_item_t  pending_requests[$];
    out_item_t expected_matrices[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        recv_hold = 1'b0;
    int        mismatches = 0;
    int        failures = 0;
    int        cycles = 0;

    sensor_frame_calibration_matrix_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // Scale a raw sample up to the 32-bit vector format.
    function automatic longint widen(sample_t v);
        return longint'(v) <<< (32 - SAMPLE_BITS);
    endfunction

    // Vectoring CORDIC: angle of (x, y) as a binary angle.
    function automatic angle_t heading(longint x, longint y);
        angle_t z = '0;
        longint dx;
        longint dy;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end else if (y < 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    // Rotation CORDIC: cosine and sine of a binary angle in Q30.
    function automatic void sincos(angle_t ang, output longint c, output longint s);
        bit     flip;
        longint x = GAIN;
        longint y = 0;
        longint z;
        longint dx;
        longint dy;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip) ang += HALF_TURN;
        z = longint'($signed(ang));
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    // Rotation about Z (is_y = 0) or about Y (is_y = 1).
    function automatic void rotation(angle_t ang, bit is_y, output mat3_t m);
        longint c;
        longint s;
        sincos(ang, c, s);
        foreach (m[r, k]) m[r][k] = 0;
        if (is_y) begin
            m[0][0] = c;  m[0][2] = s;
            m[1][1] = Q_ONE;
            m[2][0] = -s; m[2][2] = c;
        end else begin
            m[0][0] = c;  m[0][1] = s;
            m[1][0] = -s; m[1][1] = c;
            m[2][2] = Q_ONE;
        end
    endfunction

    function automatic void row_times(longint v[3], mat3_t m, output longint o[3]);
        for (int j = 0; j < 3; j++)
            o[j] = qmul(v[0], m[0][j]) + qmul(v[1], m[1][j]) + qmul(v[2], m[2][j]);
    endfunction

    function automatic void mat_product(mat3_t a, mat3_t b, output mat3_t o);
        foreach (o[r, k])
            o[r][k] = qmul(a[r][0], b[0][k]) + qmul(a[r][1], b[1][k]) +
                      qmul(a[r][2], b[2][k]);
    endfunction

    // Round a Q30 entry to the output fraction and saturate to plus or minus one.
    function automatic entry_t quantise(longint v);
        longint lim = longint'(1) <<< FRAC_BITS;
        v = (v + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return entry_t'(v);
    endfunction

    // Full calibration matrix for one request.
    function automatic out_item_t calibration_matrix(in_item_t req);
        longint g[3];
        longint h[3];
        longint w[3];
        longint u[3];
        mat3_t  r1;
        mat3_t  r2;
        mat3_t  r3;
        mat3_t  a;
        mat3_t  res;
        entry_t e [9];
        g = '{widen(req.gravity_x), widen(req.gravity_y), widen(req.gravity_z)};
        h = '{widen(req.second_x), widen(req.second_y), widen(req.second_z)};
        rotation(32'd0 - heading(g[0], g[1]), 1'b0, r1);
        row_times(g, r1, w);
        rotation(heading(w[2], w[0]), 1'b1, r2);
        mat_product(r1, r2, a);
        row_times(h, a, u);
        rotation(32'd0 - heading(u[0], u[1]), 1'b0, r3);
        mat_product(a, r3, res);
        foreach (res[r, k]) e[r*3 + k] = quantise(res[r][k]);
        return '{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    endfunction

    // Request driver: records each accepted request and offers the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_matrices.push_back(calibration_matrix(s_data));
            if (s_valid && !s_ready) begin
                // Hold the current request until it is taken.
            end else if (pending_requests.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_requests.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus the long hold-off.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor: compare every entry with the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_matrices.size() == 0) begin
                failures++;
                if (mismatches < 10)
                    $display("Unexpected result %h", m_data);
                mismatches++;
            end else begin
                want = expected_matrices.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (want[(8-k)*16 +: 16] !== m_data[(8-k)*16 +: 16]) begin
                        failures++;
                        if (mismatches < 10)
                            $display("Entry r%0dc%0d: expected %0d, got %0d", k / 3, k % 3,
                                     $signed(want[(8-k)*16 +: 16]),
                                     $signed(m_data[(8-k)*16 +: 16]));
                        mismatches++;
                    end
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic sample_t rand_sample(int kind);
        case (kind)
            0: return sample_t'($urandom);
            1: return sample_t'($signed($urandom_range(64)) - 32);
            2: return sample_t'($signed($urandom_range(4000)) - 2000);
            default: return ($urandom_range(1) ? 16'sh7FFF : 16'sh8000);
        endcase
    endfunction

    // Random request: mostly full range, some small, some at the extremes, some with zeroed axes.
    function automatic in_item_t rand_request();
        in_item_t r;
        int kind = $urandom_range(9);
        int k = (kind < 6) ? 0 : (kind < 8) ? 1 : (kind < 9) ? 2 : 3;
        r = '{rand_sample(k), rand_sample(k), rand_sample(k),
              rand_sample(k), rand_sample(k), rand_sample(k)};
        if ($urandom_range(7) == 0) r.gravity_y = '0;
        if ($urandom_range(7) == 0) r.gravity_x = '0;
        if ($urandom_range(7) == 0) r.second_y = '0;
        return r;
    endfunction

    task automatic queue_random(int count);
        @(negedge aclk);
        repeat (count) pending_requests.push_back(rand_request());
    endtask

    // Wait until every queued request has gone and every result has come back.
    task automatic settle();
        wait (pending_requests.size() == 0 && !s_valid && expected_matrices.size() == 0);
    endtask

    // Stimulus sequence.
    initial begin
        sample_t mx;
        sample_t mn;
        mx = 16'sh7FFF;
        mn = 16'sh8000;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: zero vectors, extremes, axes and negative x.
        @(negedge aclk);
        pending_requests.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pending_requests.push_back('{mx, mx, mx, mx, mx, mx});
        pending_requests.push_back('{mn, mn, mn, mn, mn, mn});
        pending_requests.push_back('{mx, mn, mx, mn, mx, mn});
        pending_requests.push_back('{mn, mx, mn, mx, mn, mx});
        pending_requests.push_back('{16'sd0, 16'sd0, 16'sd16384, mx, 16'sd0, 16'sd0});
        pending_requests.push_back('{16'sd0, 16'sd0, mn, 16'sd0, mx, 16'sd0});
        pending_requests.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, mx});
        pending_requests.push_back('{mn, 16'sd0, 16'sd0, 16'sd0, mn, 16'sd0});
        pending_requests.push_back('{16'sd0, mx, 16'sd0, mn, 16'sd0, 16'sd0});
        pending_requests.push_back('{16'sd0, mn, 16'sd0, 16'sd0, 16'sd0, mn});
        pending_requests.push_back('{-16'sd100, 16'sd50, 16'sd1000, 16'sd300, 16'sd0,
                                     -16'sd200});
        pending_requests.push_back('{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1});
        pending_requests.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0});
        pending_requests.push_back('{16'sd100, 16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pending_requests.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd500, 16'sd500,
                                     16'sd500});
        settle();

        // No idling on either side.
        send_idle_pct = 0;  recv_stall_pct = 0;
        queue_random(90);
        settle();

        // Sender idles often.
        send_idle_pct = 61; recv_stall_pct = 0;
        queue_random(70);
        settle();

        // Receiver stalls often.
        send_idle_pct = 0;  recv_stall_pct = 61;
        queue_random(70);
        settle();

        // Both sides idle now and then.
        send_idle_pct = 16; recv_stall_pct = 16;
        queue_random(70);
        settle();

        // Long receiver hold-off so the pipeline fills and back-pressures.
        send_idle_pct = 0;  recv_stall_pct = 0;
        recv_hold = 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge aclk);
                recv_hold = 1'b0;
            end
        join_none
        queue_random(140);
        settle();
        wait (!recv_hold);

        // Final drain.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0 && expected_matrices.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
